/* rtl/wrs_pkg.sv */
// water ripple step: shared constants, queue entry type and window sum function
// used by the front end, queue, back end, top level and testbench; depends on nothing
`default_nettype none
package wrs_pkg;

    localparam int MAX_WIDTH_DEF   = 512;
    localparam int MAX_HEIGHT_DEF  = 512;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int COORD_W = 12;   // holds any coordinate up to 4095
    localparam int CFG_W   = 10;
    localparam int ADDR_W  = 2;
    localparam int SUM_W   = 21;   // 20 * 65535 fits

    localparam logic [ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 10'd320;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 10'd200;

    localparam int EDGE_WEIGHT = 3;
    localparam int DIAG_WEIGHT = 2;
    localparam int MID_HEIGHT  = 32767;
    // ceil(2^24 / 20): exact quotient for sums below 2^22
    localparam int RECIP_SHIFT = 24;
    localparam logic [19:0] RECIP_20 = 20'd838861;

    // one input item's worth of work for the back end
    typedef struct packed {
        logic [8:0][15:0]   win;
        logic [15:0]        old_above_hold;
        logic [15:0]        old_above_new;
        logic [15:0]        old_left_hold;
        logic [15:0]        old_cur;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] wlast;
        logic               top;
        logic               left;
        logic [3:0]         mask;
    } entry_t;

    function automatic logic [15:0] win_at(input logic [8:0][15:0] win,
                                           input logic [1:0] r, input logic [1:0] c);
        logic [3:0] idx;
        idx = 4'(r) * 4'd3 + 4'(c);
        return win[idx];
    endfunction

    function automatic logic [SUM_W-1:0] wsum(input logic [8:0][15:0] win,
                                              input logic [1:0] tr, input logic [1:0] mr,
                                              input logic [1:0] br, input logic [1:0] lc,
                                              input logic [1:0] mc, input logic [1:0] rc);
        logic [SUM_W-1:0] edge_s;
        logic [SUM_W-1:0] diag_s;
        edge_s = SUM_W'(win_at(win, tr, mc)) + SUM_W'(win_at(win, br, mc))
               + SUM_W'(win_at(win, mr, lc)) + SUM_W'(win_at(win, mr, rc));
        diag_s = SUM_W'(win_at(win, tr, lc)) + SUM_W'(win_at(win, tr, rc))
               + SUM_W'(win_at(win, br, lc)) + SUM_W'(win_at(win, br, rc));
        return SUM_W'(EDGE_WEIGHT) * edge_s + SUM_W'(DIAG_WEIGHT) * diag_s;
    endfunction

endpackage
`default_nettype wire

/* rtl/wrs_front.sv */
// front end: input beat acceptance, raster counters, line store and 3x3 window
// builds one queue entry per pixel that releases results; uses wrs_pkg
`default_nettype none
module wrs_front #(
    parameter int MAX_WIDTH  = wrs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = wrs_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [15:0]                s_height_now,
    input  wire logic [15:0]                s_height_before,
    input  wire logic                       cfg_wr_en,
    input  wire logic [wrs_pkg::ADDR_W-1:0] cfg_addr,
    input  wire logic [wrs_pkg::CFG_W-1:0]  cfg_wr_data,
    input  wire logic                       q_full,
    output logic                            q_push,
    output wrs_pkg::entry_t                 q_entry
);
    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [wrs_pkg::CFG_W-1:0] fw_reg, fh_reg;
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;
    logic [31:0]   w_lim, h_lim;
    logic [CW-1:0] w_last, c_eff;
    logic [RW-1:0] h_last, r_eff;
    logic          s_fire;

    logic          s1_valid_reg;
    logic [15:0]   s1_now_reg, s1_before_reg;
    logic [CW-1:0] s1_col_reg, s1_wlast_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_rowend_reg, s1_lastrow_reg;
    logic [47:0]   rd_reg;       // upper, middle, old
    logic          s1_fire;
    logic [47:0]   wr_data;

    logic [47:0]   line_mem [MAX_WIDTH];
    logic [8:0][15:0] win_reg, win_next;
    logic [15:0]   oah_reg, olh_reg;
    logic [3:0]    mask;
    logic          r_ge1, c_ge1;

    always_comb begin
        if (32'(fw_reg) < 32'd2) begin
            w_lim = 32'd2;
        end else if (32'(fw_reg) > 32'(MAX_WIDTH)) begin
            w_lim = 32'(MAX_WIDTH);
        end else begin
            w_lim = 32'(fw_reg);
        end
        if (32'(fh_reg) < 32'd2) begin
            h_lim = 32'd2;
        end else if (32'(fh_reg) > 32'(MAX_HEIGHT)) begin
            h_lim = 32'(MAX_HEIGHT);
        end else begin
            h_lim = 32'(fh_reg);
        end
        w_last = CW'(w_lim - 32'd1);
        h_last = RW'(h_lim - 32'd1);
        c_eff  = (col_cnt_reg > w_last) ? w_last : col_cnt_reg;
        r_eff  = (row_cnt_reg > h_last) ? h_last : row_cnt_reg;
    end

    assign s_fire  = s_valid && s_ready;
    assign r_ge1   = (s1_row_reg != '0);
    assign c_ge1   = (s1_col_reg != '0);
    assign mask    = {r_ge1 && s1_lastrow_reg && s1_rowend_reg,
                      r_ge1 && s1_lastrow_reg && c_ge1,
                      r_ge1 && s1_rowend_reg,
                      r_ge1 && c_ge1};
    assign s1_fire = s1_valid_reg && ((mask == 4'd0) || !q_full);
    assign s_ready = !s1_valid_reg || s1_fire;
    assign q_push  = s1_fire && (mask != 4'd0);
    assign wr_data = {rd_reg[31:16], s1_now_reg, s1_before_reg};

    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (cfg_wr_en && (cfg_addr == wrs_pkg::REG_FRAME_WIDTH
                          || cfg_addr == wrs_pkg::REG_FRAME_HEIGHT)) begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end else if (s_fire) begin
            if (c_eff == w_last) begin
                col_cnt_next = '0;
                row_cnt_next = (r_eff == h_last) ? '0 : r_eff + 1'b1;
            end else begin
                col_cnt_next = c_eff + 1'b1;
                row_cnt_next = r_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg       <= wrs_pkg::FRAME_WIDTH_RST;
            fh_reg       <= wrs_pkg::FRAME_HEIGHT_RST;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_addr == wrs_pkg::REG_FRAME_WIDTH) begin
                fw_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_addr == wrs_pkg::REG_FRAME_HEIGHT) begin
                fh_reg <= cfg_wr_data;
            end
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // line store: read on accept, written back when the item leaves stage one
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            line_mem[s1_col_reg] <= wr_data;
        end
        if (s_fire) begin
            rd_reg <= (s1_fire && s1_col_reg == c_eff) ? wr_data : line_mem[c_eff];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_now_reg     <= s_height_now;
            s1_before_reg  <= s_height_before;
            s1_col_reg     <= c_eff;
            s1_row_reg     <= r_eff;
            s1_wlast_reg   <= w_last;
            s1_rowend_reg  <= (c_eff == w_last);
            s1_lastrow_reg <= (r_eff == h_last);
        end
        if (s1_fire) begin
            win_reg <= win_next;
            oah_reg <= rd_reg[15:0];
            olh_reg <= s1_before_reg;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r*3]   = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = rd_reg[47:32];
        win_next[5] = rd_reg[31:16];
        win_next[8] = s1_now_reg;
    end

    always_comb begin
        q_entry.win            = win_next;
        q_entry.old_above_hold = oah_reg;
        q_entry.old_above_new  = rd_reg[15:0];
        q_entry.old_left_hold  = olh_reg;
        q_entry.old_cur        = s1_before_reg;
        q_entry.col            = wrs_pkg::COORD_W'(s1_col_reg);
        q_entry.row            = wrs_pkg::COORD_W'(s1_row_reg);
        q_entry.wlast          = wrs_pkg::COORD_W'(s1_wlast_reg);
        q_entry.top            = (s1_row_reg == RW'(1));
        q_entry.left           = (s1_col_reg == CW'(1));
        q_entry.mask           = mask;
    end

endmodule
`default_nettype wire

/* rtl/wrs_fifo.sv */
// short queue of work entries between front and back ends
// entry type from wrs_pkg
`default_nettype none
module wrs_fifo #(
    parameter int DEPTH = wrs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire wrs_pkg::entry_t  push_data,
    input  wire logic             pop,
    output wrs_pkg::entry_t       head,
    output logic                  full,
    output logic                  empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    wrs_pkg::entry_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] cnt_reg;

    assign full  = (cnt_reg == NW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

/* rtl/wrs_back.sv */
// back end: walks each entry's pending results through three stages of ripple arithmetic,
// the last being the result output register; uses wrs_pkg
`default_nettype none
module wrs_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire wrs_pkg::entry_t  head,
    input  wire logic             q_empty,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [15:0]           m_new_height,
    output logic [8:0]            m_pixel_column,
    output logic [8:0]            m_pixel_row,
    output logic                  m_last_of_group,
    output logic                  m_last_of_frame
);
    logic [3:0] done_reg, remaining, sel;
    logic       adv, issue, last_sel, hi_row, right;
    logic [1:0] tr, mr, lc, mc;
    logic [15:0] old_sel;
    logic [wrs_pkg::COORD_W-1:0] col_sel, row_sel;

    logic                        b0_valid_reg, b1_valid_reg;
    logic [wrs_pkg::SUM_W-1:0]   b0_sum_reg;
    logic [15:0]                 b0_old_reg, b1_old_reg, b1_s_reg;
    logic [wrs_pkg::COORD_W-1:0] b0_col_reg, b0_row_reg, b1_col_reg, b1_row_reg;
    logic                        b0_lg_reg, b0_lf_reg, b1_lg_reg, b1_lf_reg;
    logic [40:0]                 prod;
    logic signed [17:0]          nv;
    logic signed [23:0]          t, tq;

    logic        m_valid_reg;
    logic [15:0] out_h_reg;
    logic [8:0]  out_c_reg, out_r_reg;
    logic        out_lg_reg, out_lf_reg;

    assign adv       = !m_valid_reg || m_ready;
    assign remaining = head.mask & ~done_reg;
    assign sel       = remaining & (~remaining + 4'd1);
    assign last_sel  = ((remaining & ~sel) == 4'd0);
    assign issue     = !q_empty && adv;
    assign q_pop     = issue && last_sel;
    assign hi_row    = sel[2] | sel[3];
    assign right     = sel[1] | sel[3];

    always_comb begin
        tr = hi_row ? 2'd1 : (head.top ? 2'd1 : 2'd0);
        mr = hi_row ? 2'd2 : 2'd1;
        lc = right ? 2'd1 : (head.left ? 2'd1 : 2'd0);
        mc = right ? 2'd2 : 2'd1;
        case (sel)
            4'b0001: old_sel = head.old_above_hold;
            4'b0010: old_sel = head.old_above_new;
            4'b0100: old_sel = head.old_left_hold;
            default: old_sel = head.old_cur;
        endcase
        col_sel = right ? head.wlast : head.col - 1'b1;
        row_sel = hi_row ? head.row : head.row - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg     <= '0;
            b0_valid_reg <= 1'b0;
            b1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            b0_valid_reg <= issue;
            b1_valid_reg <= b0_valid_reg;
            m_valid_reg  <= b1_valid_reg;
            if (issue) begin
                done_reg <= last_sel ? 4'd0 : (done_reg | sel);
            end
        end
    end

    // divide by 20 as a reciprocal multiply
    assign prod = 41'(b0_sum_reg) * 41'(wrs_pkg::RECIP_20);
    always_comb begin
        nv = $signed({1'b0, b1_s_reg, 1'b0}) - $signed({2'b00, b1_old_reg});
        t  = 24'(wrs_pkg::MID_HEIGHT) + (24'(nv) <<< 5) - 24'(nv);
        // truncate toward zero on the divide by 32
        tq = (t + (t[23] ? 24'sd31 : 24'sd0)) >>> 5;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b0_sum_reg <= wrs_pkg::wsum(head.win, tr, mr, 2'd2, lc, mc, 2'd2);
            b0_old_reg <= old_sel;
            b0_col_reg <= col_sel;
            b0_row_reg <= row_sel;
            b0_lg_reg  <= last_sel;
            b0_lf_reg  <= sel[3];
            b1_s_reg   <= prod[wrs_pkg::RECIP_SHIFT +: 16];
            b1_old_reg <= b0_old_reg;
            b1_col_reg <= b0_col_reg;
            b1_row_reg <= b0_row_reg;
            b1_lg_reg  <= b0_lg_reg;
            b1_lf_reg  <= b0_lf_reg;
            out_h_reg  <= tq[15:0];
            out_c_reg  <= b1_col_reg[8:0];
            out_r_reg  <= b1_row_reg[8:0];
            out_lg_reg <= b1_lg_reg;
            out_lf_reg <= b1_lf_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_new_height    = out_h_reg;
    assign m_pixel_column  = out_c_reg;
    assign m_pixel_row     = out_r_reg;
    assign m_last_of_group = out_lg_reg;
    assign m_last_of_frame = out_lf_reg;

endmodule
`default_nettype wire

/* rtl/water_ripple_step_core.sv */
// top level of the water ripple step: front end, work queue and back end
// depends on wrs_pkg, wrs_front, wrs_fifo, wrs_back
//
//   port group   direction  handshake          payload
//   s_*          in         s_valid/s_ready    height_now, height_before
//   m_*          out        m_valid/m_ready    new_height, column, row, last flags
//   cfg_*        in         cfg_wr_en          register index and data
//
// one input beat per cycle while the queue has room; an item waits in the
// stage-one registers, and each result passes b0, b1 and the output register
// the back end issues one result per cycle unless stalled, so rows ending or the
// last row (two to four results per beat) throttle input once the queue fills
// reset is synchronous; line store contents are not cleared
// a stalled m_ready holds the whole back end; the front end runs until the
// queue is full
`default_nettype none
module water_ripple_step_core #(
    parameter int MAX_WIDTH   = wrs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = wrs_pkg::MAX_HEIGHT_DEF,
    parameter int QUEUE_DEPTH = wrs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [15:0]                s_height_now,
    input  wire logic [15:0]                s_height_before,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [15:0]                     m_new_height,
    output logic [8:0]                      m_pixel_column,
    output logic [8:0]                      m_pixel_row,
    output logic                            m_last_of_group,
    output logic                            m_last_of_frame,
    input  wire logic                       cfg_wr_en,
    input  wire logic [wrs_pkg::ADDR_W-1:0] cfg_addr,
    input  wire logic [wrs_pkg::CFG_W-1:0]  cfg_wr_data
);
    logic            q_full, q_empty, q_push, q_pop;
    wrs_pkg::entry_t q_entry, q_head;

    wrs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_height_now    (s_height_now),
        .s_height_before (s_height_before),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (q_entry)
    );

    wrs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_entry),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    wrs_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (q_head),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_new_height    (m_new_height),
        .m_pixel_column  (m_pixel_column),
        .m_pixel_row     (m_pixel_row),
        .m_last_of_group (m_last_of_group),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule
`default_nettype wire

/* rtl/wrs_checker.sv */
// port-level checks for water_ripple_step_core, attached by bind
// sees only the top level ports
`default_nettype none
module wrs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_new_height,
    input wire logic [8:0]  m_pixel_column,
    input wire logic [8:0]  m_pixel_row,
    input wire logic        m_last_of_group,
    input wire logic        m_last_of_frame
);
    // a stalled result beat keeps its height, column and row
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_height)
            && $stable(m_pixel_column) && $stable(m_pixel_row))
        else $error("result beat changed while stalled");

    a_frame_ends_group: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_of_frame |-> m_last_of_group)
        else $error("frame end not at group end");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a frame end result never lies on the top row
    a_frame_end_next_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_of_frame |-> m_pixel_row != 9'd0)
        else $error("frame end reported on top row");

endmodule

bind water_ripple_step_core wrs_checker u_wrs_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_new_height    (m_new_height),
    .m_pixel_column  (m_pixel_column),
    .m_pixel_row     (m_pixel_row),
    .m_last_of_group (m_last_of_group),
    .m_last_of_frame (m_last_of_frame)
);
`default_nettype wire

/* tb/tb_top.sv */
// testbench for water_ripple_step_core: streams height maps through the block and
// checks every result against an in-bench predictor of the 3x3 ripple update
// depends on wrs_pkg and the rtl of the block
`default_nettype none
module tb_top;

    localparam logic [wrs_pkg::ADDR_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [wrs_pkg::ADDR_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [15:0] height;
        logic [8:0]  col;
        logic [8:0]  row;
        logic        group_end;
        logic        frame_end;
    } ripple_out_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [15:0]                s_height_now = '0;
    logic [15:0]                s_height_before = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [15:0]                m_new_height;
    logic [8:0]                 m_pixel_column;
    logic [8:0]                 m_pixel_row;
    logic                       m_last_of_group;
    logic                       m_last_of_frame;
    logic                       cfg_wr_en = 1'b0;
    logic [wrs_pkg::ADDR_W-1:0] cfg_addr = '0;
    logic [wrs_pkg::CFG_W-1:0]  cfg_wr_data = '0;

    // predictor state
    logic [wrs_pkg::CFG_W-1:0] width_reg;
    logic [wrs_pkg::CFG_W-1:0] height_reg;
    logic [15:0] upper_line [512];
    logic [15:0] middle_line [512];
    logic [15:0] old_line [512];
    logic [15:0] win [9];
    logic [15:0] old_above_q;
    logic [15:0] old_left_q;
    int col_pos;
    int row_pos;

    ripple_out_t pending_heights[$];
    int error_count = 0;
    int beats_sent = 0;
    int results_seen = 0;
    int frames_done = 0;
    int beat_tag = 0;
    logic no_idle = 1'b0;

    water_ripple_step_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_height_now(s_height_now), .s_height_before(s_height_before),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_new_height(m_new_height), .m_pixel_column(m_pixel_column),
        .m_pixel_row(m_pixel_row), .m_last_of_group(m_last_of_group),
        .m_last_of_frame(m_last_of_frame),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic int fit_size(logic [wrs_pkg::CFG_W-1:0] v, int hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic logic [15:0] damped_height(int tr, int mr, int br, int lc, int mc,
                                                  int rc, logic [15:0] old);
        int e, d, s, nv, q;
        e = win[tr*3+mc] + win[br*3+mc] + win[mr*3+lc] + win[mr*3+rc];
        d = win[tr*3+lc] + win[tr*3+rc] + win[br*3+lc] + win[br*3+rc];
        s = (wrs_pkg::EDGE_WEIGHT * e + wrs_pkg::DIAG_WEIGHT * d) / 20;
        nv = 2 * s - int'(old);
        q = (wrs_pkg::MID_HEIGHT + 31 * nv) / 32;
        return q[15:0];
    endfunction

    function automatic void push_height(logic [15:0] v, int x, int y, logic lastf);
        ripple_out_t o;
        o.height = v;
        o.col = x[8:0];
        o.row = y[8:0];
        o.group_end = 1'b0;
        o.frame_end = lastf;
        pending_heights.push_back(o);
    endfunction

    function automatic void predict_beat(logic [15:0] now, logic [15:0] old_cur);
        int w, h, c, r, n0, top, left;
        logic row_end, last_row;
        logic [15:0] old_above_new;
        w = fit_size(width_reg, 512);
        h = fit_size(height_reg, 512);
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        row_end = (c == w - 1);
        last_row = (r == h - 1);
        n0 = pending_heights.size();
        for (int i = 0; i < 3; i++) begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = upper_line[c];
        win[5] = middle_line[c];
        win[8] = now;
        old_above_new = old_line[c];
        if (r >= 1) begin
            top = (r == 1) ? 1 : 0;
            left = (c == 1) ? 1 : 0;
            if (c >= 1)
                push_height(damped_height(top, 1, 2, left, 1, 2, old_above_q), c-1, r-1, 0);
            if (row_end)
                push_height(damped_height(top, 1, 2, 1, 2, 2, old_above_new), w-1, r-1, 0);
            if (last_row) begin
                if (c >= 1)
                    push_height(damped_height(1, 2, 2, left, 1, 2, old_left_q), c-1, r, 0);
                if (row_end) begin
                    push_height(damped_height(1, 2, 2, 1, 2, 2, old_cur), w-1, r, 1);
                    frames_done++;
                end
            end
        end
        if (pending_heights.size() > n0)
            pending_heights[pending_heights.size()-1].group_end = 1'b1;
        upper_line[c] = middle_line[c];
        middle_line[c] = now;
        old_line[c] = old_cur;
        old_above_q = old_above_new;
        old_left_q = old_cur;
        if (row_end) begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    // result side: ready pattern and checking
    always @(negedge aclk)
        m_ready <= no_idle || ($urandom_range(99) >= 31);

    always begin
        ripple_out_t exp_o;
        @(posedge aclk);
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_heights.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result col %0d row %0d height %0h", $time,
                         m_pixel_column, m_pixel_row, m_new_height);
            end else begin
                exp_o = pending_heights.pop_front();
                if (m_new_height !== exp_o.height || m_pixel_column !== exp_o.col ||
                    m_pixel_row !== exp_o.row || m_last_of_group !== exp_o.group_end ||
                    m_last_of_frame !== exp_o.frame_end) begin
                    error_count++;
                    $display("%0t: mismatch expected h=%h c=%0d r=%0d lg=%b lf=%b",
                             $time, exp_o.height, exp_o.col, exp_o.row, exp_o.group_end,
                             exp_o.frame_end);
                    $display("%0t:          actual   h=%h c=%0d r=%0d lg=%b lf=%b",
                             $time, m_new_height, m_pixel_column, m_pixel_row,
                             m_last_of_group, m_last_of_frame);
                end
            end
        end
    end

    task automatic send_beat(logic [15:0] now, logic [15:0] old_cur);
        logic taken;
        int my_tag;
        while (!no_idle && $urandom_range(99) < 31) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_height_now = now;
        s_height_before = old_cur;
        beat_tag++;
        my_tag = beat_tag;
        taken = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            taken = s_ready;
        end
        predict_beat(now, old_cur);
        beats_sent++;
        // drop valid unless the next beat raises it at this same falling edge
        fork
            begin
                @(negedge aclk);
                if (beat_tag == my_tag)
                    s_valid = 1'b0;
            end
        join_none
    endtask

    task automatic wait_drained();
        wait (pending_heights.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [wrs_pkg::ADDR_W-1:0] idx, logic [wrs_pkg::CFG_W-1:0] val);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == wrs_pkg::REG_FRAME_WIDTH || idx == wrs_pkg::REG_FRAME_HEIGHT) begin
            if (idx == wrs_pkg::REG_FRAME_WIDTH) width_reg = val;
            else height_reg = val;
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    function automatic logic [15:0] pick_height();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pixels(int n);
        for (int i = 0; i < n; i++)
            send_beat(pick_height(), pick_height());
    endtask

    task automatic test_reset_size();
        // default geometry, a few pixels of the top row release nothing
        send_pixels(6);
    endtask

    task automatic test_field_extremes();
        write_reg(wrs_pkg::REG_FRAME_WIDTH, 10'd2);
        write_reg(wrs_pkg::REG_FRAME_HEIGHT, 10'd2);
        for (int i = 0; i < 4; i++) send_beat(16'h0000, 16'h0000);
        for (int i = 0; i < 4; i++) send_beat(16'hffff, 16'hffff);
        for (int i = 0; i < 4; i++) send_beat(16'hffff, 16'h0000);
        for (int i = 0; i < 4; i++) send_beat(16'h0000, 16'hffff);
        send_beat(16'h8000, 16'h7fff);
        send_beat(16'h7fff, 16'h8000);
        send_beat(16'h5555, 16'haaaa);
        send_beat(16'haaaa, 16'h5555);
    endtask

    task automatic test_clamped_sizes();
        // sizes below two act as two, above the maximum as the maximum
        write_reg(wrs_pkg::REG_FRAME_WIDTH, 10'd0);
        write_reg(wrs_pkg::REG_FRAME_HEIGHT, 10'd1);
        send_pixels(4);
        write_reg(wrs_pkg::REG_FRAME_WIDTH, 10'd1023);
        write_reg(wrs_pkg::REG_FRAME_HEIGHT, 10'd2);
        send_pixels(6);
        write_reg(wrs_pkg::REG_FRAME_WIDTH, 10'd2);
        write_reg(wrs_pkg::REG_FRAME_HEIGHT, 10'd1023);
        send_pixels(8);
        write_reg(wrs_pkg::REG_FRAME_WIDTH, 10'd512);
        write_reg(wrs_pkg::REG_FRAME_HEIGHT, 10'd512);
        send_pixels(5);
    endtask

    task automatic test_spare_index();
        write_reg(wrs_pkg::REG_FRAME_WIDTH, 10'd5);
        write_reg(wrs_pkg::REG_FRAME_HEIGHT, 10'd3);
        send_pixels(7);
        // writes to unused indexes change nothing, frame position is kept
        write_reg(REG_SPARE_2, 10'h3ff);
        write_reg(REG_SPARE_3, 10'h001);
        send_pixels(8);
    endtask

    task automatic test_restart_mid_frame();
        write_reg(wrs_pkg::REG_FRAME_WIDTH, 10'd6);
        write_reg(wrs_pkg::REG_FRAME_HEIGHT, 10'd4);
        send_pixels(14);
        write_reg(wrs_pkg::REG_FRAME_WIDTH, 10'd4);
        send_pixels(4 * 4);
        write_reg(wrs_pkg::REG_FRAME_HEIGHT, 10'd3);
        send_pixels(4 * 3);
    endtask

    task automatic test_random_frames();
        int w, h, n;
        n = 0;
        while (n < 20) begin
            w = $urandom_range(10, 2);
            h = $urandom_range(6, 2);
            write_reg(wrs_pkg::REG_FRAME_WIDTH, wrs_pkg::CFG_W'(w));
            write_reg(wrs_pkg::REG_FRAME_HEIGHT, wrs_pkg::CFG_W'(h));
            no_idle = ($urandom_range(3) == 0);
            for (int f = $urandom_range(2, 1); f > 0; f--) begin
                // now and then a frame is cut short
                if ($urandom_range(5) == 0) send_pixels($urandom_range(w * h - 1, 1));
                else send_pixels(w * h);
                n += w * h;
                if ($urandom_range(5) == 0) break;
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        width_reg = wrs_pkg::FRAME_WIDTH_RST;
        height_reg = wrs_pkg::FRAME_HEIGHT_RST;
        for (int i = 0; i < 512; i++) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
            old_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        old_above_q = '0;
        old_left_q = '0;
        col_pos = 0;
        row_pos = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_size();
        test_field_extremes();
        test_clamped_sizes();
        test_spare_index();
        test_restart_mid_frame();
        test_random_frames();

        wait_drained();
        $display("run covered %0d input beats and %0d results, %0d whole frames",
                 beats_sent, results_seen, frames_done);
        $display("sizes from 2x2 to clamped 512x512, spare index writes, restarted frames");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #8000000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_heights.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
